// ===== rtl/core/lkvc_pkg.sv =====
// Shared types and constants of the LRU key/value cache.
package lkvc_pkg;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  localparam int unsigned DATA_BITS = 32;
  localparam int unsigned CAP_BITS  = 5;

  localparam logic [DATA_BITS-1:0] MISS_VALUE = {DATA_BITS{1'b1}};

  typedef struct packed {
    logic load;
    logic take_front;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/lkvc_if.sv =====
// Valid/ready channel interfaces for requests and results of the cache.
interface lkvc_req_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic signed [lkvc_pkg::DATA_BITS-1:0] key;
  logic signed [lkvc_pkg::DATA_BITS-1:0] value;

  modport source (output valid, output mode, output key, output value, input ready);
  modport sink (input valid, input mode, input key, input value, output ready);
endinterface

interface lkvc_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic signed [lkvc_pkg::DATA_BITS-1:0] read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink (input valid, input hit, input read_value, output ready);
endinterface

// ===== rtl/core/lkvc_cell.sv =====
// One recency slot of the cache: holds a key and value and compares the probe key.
module lkvc_cell #(
  parameter int unsigned KW = 32
) (
  input  logic                                 clk,
  input  lkvc_pkg::cell_ctrl_t                 ctrl,
  input  logic [KW-1:0]                        front_key,
  input  logic [lkvc_pkg::DATA_BITS-1:0]       front_value,
  input  logic [KW-1:0]                        prev_key,
  input  logic [lkvc_pkg::DATA_BITS-1:0]       prev_value,
  input  logic [KW-1:0]                        probe_key,
  output logic [KW-1:0]                        key,
  output logic [lkvc_pkg::DATA_BITS-1:0]       value,
  output logic                                 match
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      if (ctrl.take_front) begin
        key   <= front_key;
        value <= front_value;
      end else begin
        key   <= prev_key;
        value <= prev_value;
      end
    end
  end

  assign match = (key == probe_key);

endmodule

// ===== rtl/core/lru_key_value_cache_core.sv =====
// Top level of the LRU key/value cache: a row of recency-ordered cells.
// The cells are kept in order of recency, the most recent entry in the first cell and the
// least recent valid entry in the last occupied one. Every request is compared against all
// cells in the cycle it is accepted; a hit moves its entry to the first cell while the more
// recent entries step one cell down the row, and a put of a new key shifts the whole row,
// dropping the least recent entry when the cache is full. One request is accepted per clock
// cycle, and a get's result appears in the output register on the following cycle; the
// input stalls only while an earlier result is still waiting to be taken.
module lru_key_value_cache_core #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lkvc_pkg::CAP_BITS-1:0]    cfg_data,
  lkvc_req_if.sink                         in,
  lkvc_rsp_if.source                       out
);

  localparam int unsigned KW = (KEY_BITS < lkvc_pkg::DATA_BITS) ? KEY_BITS
                                                                : lkvc_pkg::DATA_BITS;
  localparam int unsigned OW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (OW > lkvc_pkg::CAP_BITS) ? OW : lkvc_pkg::CAP_BITS;

  logic [lkvc_pkg::CAP_BITS-1:0]  capacity;
  logic [OW-1:0]                  occupancy;
  logic [CW-1:0]                  cap_ext;
  logic [CW-1:0]                  eff_cap;
  logic [KW-1:0]                  probe_key;
  logic [KW-1:0]                  cell_key [DEPTH];
  logic [lkvc_pkg::DATA_BITS-1:0] cell_value [DEPTH];
  logic [DEPTH-1:0]               raw_match;
  logic [DEPTH-1:0]               match;
  logic [DEPTH-1:0]               above;
  lkvc_pkg::cell_ctrl_t           ctrl [DEPTH];
  logic                           fire;
  logic                           hit;
  logic                           is_put;
  logic [lkvc_pkg::DATA_BITS-1:0] hit_value;
  logic [lkvc_pkg::DATA_BITS-1:0] front_value;

  assign probe_key   = in.key[KW-1:0];
  assign in.ready    = !out.valid || out.ready;
  assign fire        = in.valid && in.ready;
  assign is_put      = (in.mode == lkvc_pkg::MODE_PUT);
  assign cap_ext     = CW'(capacity);
  assign front_value = is_put ? in.value : hit_value;

  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = raw_match[i] && (occupancy > OW'(i));
      if (match[i]) begin
        hit_value = hit_value | cell_value[i];
      end
    end
    above[DEPTH-1] = match[DEPTH-1];
    for (int i = DEPTH - 2; i >= 0; i--) begin
      above[i] = above[i+1] || match[i];
    end
    hit = |match;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign ctrl[g].load       = fire && (is_put || hit);
      assign ctrl[g].take_front = 1'b1;
    end else begin : g_body
      assign ctrl[g].load       = fire && ((is_put && !hit) || above[g]);
      assign ctrl[g].take_front = 1'b0;
    end

    lkvc_cell #(
      .KW (KW)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl[g]),
      .front_key   (probe_key),
      .front_value (front_value),
      .prev_key    (cell_key[(g == 0) ? 0 : g - 1]),
      .prev_value  (cell_value[(g == 0) ? 0 : g - 1]),
      .probe_key   (probe_key),
      .key         (cell_key[g]),
      .value       (cell_value[g]),
      .match       (raw_match[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkvc_pkg::CAP_BITS'(16);
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (fire && is_put && !hit && (CW'(occupancy) < eff_cap)) begin
      occupancy <= occupancy + OW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (fire && !is_put) begin
      out.valid <= 1'b1;
    end else if (out.ready) begin
      out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !is_put) begin
      out.hit        <= hit;
      out.read_value <= hit ? hit_value : lkvc_pkg::MISS_VALUE;
    end
  end

  // At most one occupied cell may hold the probe key.
  assert property (@(posedge clk) disable iff (rst) $onehot0(match))
    else $error("more than one cell matches the probe key");

  // The occupancy never exceeds the number of cells.
  assert property (@(posedge clk) disable iff (rst) occupancy <= OW'(DEPTH))
    else $error("occupancy beyond the number of cells");

  // A put request leaves no result behind.
  assert property (@(posedge clk) disable iff (rst) (fire && is_put) |=> !out.valid)
    else $error("put request produced a result");

  // The occupancy grows by at most one per request.
  assert property (@(posedge clk) disable iff (rst)
      !$stable(occupancy) |-> (occupancy == $past(occupancy) + OW'(1)))
    else $error("occupancy changed by more than one");

endmodule
